@@ rtl/core/kvi_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants of the keyframe vertex interpolator.
// Depends on nothing; the top level imports it.
package kvi_pkg;

   // Request codes carried by one input item.
   typedef logic [1:0] req_code_type;
   localparam req_code_type REQ_VERTEX = 2'd0;
   localparam req_code_type REQ_LENGTH = 2'd1;
   localparam req_code_type REQ_TICK   = 2'd2;

   // Configuration register indexes.
   typedef logic csr_index_type;
   localparam csr_index_type CSR_FRAME_COUNT  = 1'b0;
   localparam csr_index_type CSR_VERTEX_COUNT = 1'b1;

   // Width of the configuration write data (widest register).
   localparam int CSR_DATA_BITS = 6;

   // The key index field addresses at most this many keyframes.
   localparam int KEY_FIELD_LIMIT = 16;

   // Device transform offsets, widened to the 17-bit difference.
   localparam logic [16:0] X_OFFSET = 17'd500;
   localparam logic [16:0] Y_OFFSET = 17'd1000;

   // Stored vertex word: y in the upper half, x in the lower half.
   typedef struct packed {
      logic [15:0] y;
      logic [15:0] x;
   } vertex_word_type;

   // Clamp a 20-bit signed value into the int16 range.
   function automatic logic [15:0] sat16(input logic signed [19:0] v);
      logic [15:0] r;
      if (v > 20'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -20'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/keyframe_vertex_interpolator.sv @@
`timescale 1ns / 1ps
// Keyframe vertex interpolator: keyframe and length memories, tick sequencer,
// alpha divider and the vertex interpolation and transform pipeline.
// Depends on kvi_pkg.
//
// A write item does not raise busy. A tick item holds busy while it steps the counters;
// with no vertices in use it then returns to idle, else it fetches the new key's length,
// runs a restoring division for alpha, makes two keyframe memory reads per vertex over
// its single read port and drains the pipeline. Results leave one per vertex; the last
// one is on the ports in the cycle in which busy falls. The receiver cannot stall them.
// Reset returns to idle, clears the key index, tick counter and valid flags and sets both
// counts to one; datapath registers and memories are not cleared.
module keyframe_vertex_interpolator #(
   parameter int MAX_KEYS   = 16,
   parameter int MAX_POINTS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  kvi_pkg::req_code_type          req_type,
   input  logic [3:0]                     req_key_index,
   input  logic [4:0]                     req_point_index,
   input  logic signed [15:0]             req_coord_x,
   input  logic signed [15:0]             req_coord_y,
   input  logic [15:0]                    req_length_ticks,
   output logic                           rsp_valid,
   output logic [4:0]                     rsp_vertex_id,
   output logic signed [15:0]             rsp_out_x,
   output logic signed [15:0]             rsp_out_y,
   output logic                           rsp_last_vertex,
   input  logic                           csr_we,
   input  kvi_pkg::csr_index_type         csr_index,
   input  logic [kvi_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import kvi_pkg::*;

   // Only keys reachable through the 4-bit key field get storage.
   localparam int KEY_SLOTS = (MAX_KEYS < KEY_FIELD_LIMIT) ? MAX_KEYS : KEY_FIELD_LIMIT;
   localparam int KW        = $clog2(KEY_SLOTS);
   localparam int PW        = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int KF_DEPTH  = 2 ** (KW + PW);
   localparam int LEN_DEPTH = 2 ** KW;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_STEP  = 3'd1;
   localparam logic [2:0] ST_LEN   = 3'd2;
   localparam logic [2:0] ST_DLOAD = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_WALK  = 3'd5;
   localparam logic [2:0] ST_DRAIN = 3'd6;

   // Memories.
   vertex_word_type kf_mem [KF_DEPTH];
   logic [15:0]     len_mem [LEN_DEPTH];

   // Control registers.
   logic [2:0]  state_ff, state_in;
   logic [3:0]  key_ff, key_in;
   logic [15:0] tick_ff, tick_in;
   logic [4:0]  frame_count_ff, frame_count_in;
   logic [5:0]  vertex_count_ff, vertex_count_in;
   logic [15:0] div_ff, div_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] alpha_ff, alpha_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [PW-1:0] idx_ff, idx_in;
   logic        phase_ff, phase_in;

   // Memory read registers.
   vertex_word_type kf_rd_ff;
   logic [15:0]     len_rd_ff;

   // Pipeline registers.
   logic        cur_vld_ff, cur_vld_in;
   logic        nxt_vld_ff, nxt_vld_in;
   logic [4:0]  nxt_id_ff, nxt_id_in;
   logic        nxt_last_ff, nxt_last_in;
   logic [15:0] ax_ff, ax_in, ay_ff, ay_in;
   logic        d_vld_ff, d_vld_in;
   logic [4:0]  d_id_ff, d_id_in;
   logic        d_last_ff, d_last_in;
   logic [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [15:0] dax_ff, dax_in, day_ff, day_in;
   logic        m_vld_ff, m_vld_in;
   logic [4:0]  m_id_ff, m_id_in;
   logic        m_last_ff, m_last_in;
   logic signed [33:0] mx_ff, mx_in, my_ff, my_in;
   logic [15:0] max_ff, max_in, may_ff, may_in;
   logic        p_vld_ff, p_vld_in;
   logic [4:0]  p_id_ff, p_id_in;
   logic        p_last_ff, p_last_in;
   logic [15:0] px_ff, px_in, py_ff, py_in;
   logic        o_vld_ff, o_vld_in;
   logic [4:0]  o_id_ff, o_id_in;
   logic        o_last_ff, o_last_in;
   logic [15:0] ox_ff, ox_in, oy_ff, oy_in;

   // Combinational helpers.
   logic        accept;
   logic        key_ok, point_ok;
   logic [KW-1:0] wr_key;
   logic [PW-1:0] wr_point;
   logic [6:0]  point_wide;
   logic [4:0]  frames;
   logic [4:0]  key_plus;
   logic [4:0]  next_key;
   logic [6:0]  n_used;
   logic [6:0]  idx_wide;
   logic        idx_last;
   logic [15:0] len_eff;
   logic [16:0] tick_plus;
   logic [16:0] rem_shift;
   logic        rem_ge;
   logic [KW+PW-1:0] kf_rd_addr;
   logic [16:0] xm, ym;
   logic [18:0] x3, y3;
   logic [17:0] sumx, sumy;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Write address decode and range checks.
   assign point_wide = 7'(req_point_index);
   assign key_ok     = ({1'b0, req_key_index} < 5'(KEY_SLOTS));
   assign point_ok   = (point_wide < 7'(MAX_POINTS));
   assign wr_key     = req_key_index[KW-1:0];
   assign wr_point   = point_wide[PW-1:0];

   // Frame count clamped to 1..KEY_SLOTS, vertex count clamped to MAX_POINTS.
   always_comb begin
      if (frame_count_ff == 5'd0) begin
         frames = 5'd1;
      end else if (frame_count_ff > 5'(KEY_SLOTS)) begin
         frames = 5'(KEY_SLOTS);
      end else begin
         frames = frame_count_ff;
      end
      if (7'(vertex_count_ff) > 7'(MAX_POINTS)) begin
         n_used = 7'(MAX_POINTS);
      end else begin
         n_used = 7'(vertex_count_ff);
      end
   end

   // Following keyframe, wrapping at the frame count.
   assign key_plus = 5'(key_ff) + 5'd1;
   assign next_key = (key_plus >= frames) ? 5'd0 : key_plus;

   assign idx_wide  = 7'(idx_ff);
   assign idx_last  = (idx_wide == (n_used - 7'd1));
   assign len_eff   = (len_rd_ff == 16'd0) ? 16'd1 : len_rd_ff;
   assign tick_plus = 17'(tick_ff) + 17'd1;

   // One restoring division step.
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});

   // Current keyframe on the even read, next keyframe on the odd read.
   assign kf_rd_addr = phase_ff ? {next_key[KW-1:0], idx_ff} : {key_ff[KW-1:0], idx_ff};

   // Memories: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (accept && (req_type == REQ_VERTEX) && key_ok && point_ok) begin
         kf_mem[{wr_key, wr_point}] <= '{y: req_coord_y, x: req_coord_x};
      end
      kf_rd_ff <= kf_mem[kf_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (accept && (req_type == REQ_LENGTH) && key_ok) begin
         len_mem[wr_key] <= req_length_ticks;
      end
      len_rd_ff <= len_mem[key_ff[KW-1:0]];
   end

   // Sequencer, key and tick counters, divider and vertex walk.
   always_comb begin
      state_in        = state_ff;
      key_in          = key_ff;
      tick_in         = tick_ff;
      frame_count_in  = frame_count_ff;
      vertex_count_in = vertex_count_ff;
      div_in          = div_ff;
      rem_in          = rem_ff;
      alpha_in        = alpha_ff;
      cnt_in          = cnt_ff;
      idx_in          = idx_ff;
      phase_in        = phase_ff;
      cur_vld_in      = 1'b0;
      nxt_vld_in      = 1'b0;
      nxt_id_in       = nxt_id_ff;
      nxt_last_in     = nxt_last_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_COUNT:  frame_count_in  = csr_wdata[4:0];
            CSR_VERTEX_COUNT: vertex_count_in = csr_wdata[5:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_TICK)) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            // Length of the current key is in the read register.
            if (tick_plus >= 17'(len_eff)) begin
               tick_in = 16'd0;
               key_in  = (key_plus >= frames) ? 4'd0 : key_plus[3:0];
            end else begin
               tick_in = tick_plus[15:0];
            end
            state_in = (n_used == 7'd0) ? ST_IDLE : ST_LEN;
         end
         ST_LEN: begin
            state_in = ST_DLOAD;
         end
         ST_DLOAD: begin
            div_in   = len_eff;
            rem_in   = tick_ff;
            cnt_in   = 4'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in   = rem_ge ? 16'(rem_shift - {1'b0, div_ff}) : rem_shift[15:0];
            alpha_in = {alpha_ff[14:0], rem_ge};
            cnt_in   = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               idx_in   = '0;
               phase_in = 1'b0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            phase_in = !phase_ff;
            if (!phase_ff) begin
               cur_vld_in = 1'b1;
            end else begin
               nxt_vld_in  = 1'b1;
               nxt_id_in   = idx_wide[4:0];
               nxt_last_in = idx_last;
               if (idx_last) begin
                  state_in = ST_DRAIN;
               end else begin
                  idx_in = idx_ff + PW'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (p_vld_ff && p_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Interpolation and transform pipeline.
   always_comb begin
      // Capture the current keyframe vertex.
      ax_in = cur_vld_ff ? kf_rd_ff.x : ax_ff;
      ay_in = cur_vld_ff ? kf_rd_ff.y : ay_ff;

      // Difference toward the next keyframe.
      d_vld_in  = nxt_vld_ff;
      d_id_in   = nxt_id_ff;
      d_last_in = nxt_last_ff;
      dx_in     = {kf_rd_ff.x[15], kf_rd_ff.x} - {ax_ff[15], ax_ff};
      dy_in     = {kf_rd_ff.y[15], kf_rd_ff.y} - {ay_ff[15], ay_ff};
      dax_in    = ax_ff;
      day_in    = ay_ff;

      // Scale the difference by alpha.
      m_vld_in  = d_vld_ff;
      m_id_in   = d_id_ff;
      m_last_in = d_last_ff;
      mx_in     = $signed(dx_ff) * $signed({1'b0, alpha_ff});
      my_in     = $signed(dy_ff) * $signed({1'b0, alpha_ff});
      max_in    = dax_ff;
      may_in    = day_ff;

      // Add the floored step to the current vertex; it stays between the keys.
      p_vld_in  = m_vld_ff;
      p_id_in   = m_id_ff;
      p_last_in = m_last_ff;
      sumx      = {max_ff[15], max_ff[15], max_ff} + mx_ff[33:16];
      sumy      = {may_ff[15], may_ff[15], may_ff} + my_ff[33:16];
      px_in     = sumx[15:0];
      py_in     = sumy[15:0];

      // Device transform with floor shifts and saturation.
      o_vld_in  = p_vld_ff;
      o_id_in   = p_id_ff;
      o_last_in = p_last_ff;
      xm        = {px_ff[15], px_ff} - X_OFFSET;
      ym        = {py_ff[15], py_ff} - Y_OFFSET;
      x3        = {xm[16], xm, 1'b0} + {xm[16], xm[16], xm};
      y3        = {ym[16], ym, 1'b0} + {ym[16], ym[16], ym};
      ox_in     = sat16({{4{x3[18]}}, x3[18:3]});
      oy_in     = sat16({{2{y3[18]}}, y3[18:1]});
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         key_ff          <= 4'd0;
         tick_ff         <= 16'd0;
         frame_count_ff  <= 5'd1;
         vertex_count_ff <= 6'd1;
         cur_vld_ff      <= 1'b0;
         nxt_vld_ff      <= 1'b0;
         d_vld_ff        <= 1'b0;
         m_vld_ff        <= 1'b0;
         p_vld_ff        <= 1'b0;
         o_vld_ff        <= 1'b0;
      end else begin
         state_ff        <= state_in;
         key_ff          <= key_in;
         tick_ff         <= tick_in;
         frame_count_ff  <= frame_count_in;
         vertex_count_ff <= vertex_count_in;
         cur_vld_ff      <= cur_vld_in;
         nxt_vld_ff      <= nxt_vld_in;
         d_vld_ff        <= d_vld_in;
         m_vld_ff        <= m_vld_in;
         p_vld_ff        <= p_vld_in;
         o_vld_ff        <= o_vld_in;
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      alpha_ff    <= alpha_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      phase_ff    <= phase_in;
      nxt_id_ff   <= nxt_id_in;
      nxt_last_ff <= nxt_last_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      d_id_ff     <= d_id_in;
      d_last_ff   <= d_last_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dax_ff      <= dax_in;
      day_ff      <= day_in;
      m_id_ff     <= m_id_in;
      m_last_ff   <= m_last_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      max_ff      <= max_in;
      may_ff      <= may_in;
      p_id_ff     <= p_id_in;
      p_last_ff   <= p_last_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      o_id_ff     <= o_id_in;
      o_last_ff   <= o_last_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
   end

   // Result ports.
   assign rsp_valid       = o_vld_ff;
   assign rsp_vertex_id   = o_id_ff;
   assign rsp_out_x       = ox_ff;
   assign rsp_out_y       = oy_ff;
   assign rsp_last_vertex = o_last_ff;

endmodule

@@ dv/tb_keyframe_vertex_interpolator.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for keyframe_vertex_interpolator: directed and random items,
// with results checked against an in-bench prediction. Depends on kvi_pkg and the RTL.
module tb_keyframe_vertex_interpolator;
   import kvi_pkg::*;

   localparam int MAX_KEYS     = 16;
   localparam int MAX_POINTS   = 32;
   localparam int TAIL_CYCLES  = 120;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int PHASE_ITEMS  = 36;
   localparam int PHASE_TOTAL  = 8;

   // Request code 3 has no meaning and must be dropped by the block.
   localparam req_code_type REQ_RESERVED = 2'd3;

   typedef struct packed {
      logic [4:0]  id;
      logic [15:0] x;
      logic [15:0] y;
      logic        last;
   } vertex_result_type;

   // Scoreboard: mirrors the keyframe state and queues the vertices each tick must emit.
   class interp_scoreboard;
      logic [15:0] key_x [MAX_KEYS][MAX_POINTS];
      logic [15:0] key_y [MAX_KEYS][MAX_POINTS];
      bit          vertex_loaded [MAX_KEYS][MAX_POINTS];
      logic [15:0] key_length [MAX_KEYS];
      bit          length_loaded [MAX_KEYS];
      logic [3:0]  key_now;
      logic [15:0] subframe;
      logic [4:0]  frame_count;
      logic [5:0]  vertex_count;
      vertex_result_type expected_vertices [$];
      int          mismatch_count;

      function new();
         key_now = '0;
         subframe = '0;
         frame_count = 5'd1;
         vertex_count = 6'd1;
         mismatch_count = 0;
      endfunction

      function int frames_in_use();
         int f;
         f = frame_count;
         if (f < 1) f = 1;
         if (f > KEY_FIELD_LIMIT) f = KEY_FIELD_LIMIT;
         return f;
      endfunction

      function int points_in_use();
         return (vertex_count > MAX_POINTS) ? MAX_POINTS : int'(vertex_count);
      endfunction

      // A stored length of zero behaves as one tick.
      function int length_in_use(logic [3:0] key);
         return (key_length[key] == 16'd0) ? 1 : int'(key_length[key]);
      endfunction

      function void write_reg(csr_index_type idx, logic [5:0] data);
         if (idx == CSR_FRAME_COUNT) begin
            frame_count = data[4:0];
         end else if (idx == CSR_VERTEX_COUNT) begin
            vertex_count = data;
         end
      endfunction

      // Moves one coordinate from the current toward the next keyframe, rounding down.
      function longint blend(logic [15:0] from_raw, logic [15:0] to_raw, longint alpha);
         longint a;
         longint b;
         a = $signed(from_raw);
         b = $signed(to_raw);
         return a + (((b - a) * alpha) >>> 16);
      endfunction

      function logic [15:0] clip_int16(longint v);
         if (v > 32767) return 16'h7FFF;
         if (v < -32768) return 16'h8000;
         return v[15:0];
      endfunction

      // Advances the animation clock by one tick and queues every vertex it emits.
      function void predict_tick();
         int frames;
         int npts;
         int len;
         int nxt;
         int step;
         longint alpha;
         longint pos_x;
         longint pos_y;
         vertex_result_type r;
         frames = frames_in_use();
         step = subframe + 1;
         if (step >= length_in_use(key_now)) begin
            step = 0;
            key_now = key_now + 4'd1;
            if (key_now >= frames) key_now = '0;
         end
         subframe = step[15:0];
         len = length_in_use(key_now);
         alpha = (longint'(subframe) << 16) / len;
         if (alpha > 65535) alpha = 65535;
         nxt = key_now + 1;
         if (nxt >= frames) nxt = 0;
         npts = points_in_use();
         for (int i = 0; i < npts; i++) begin
            pos_x = blend(key_x[key_now][i], key_x[nxt][i], alpha);
            pos_y = blend(key_y[key_now][i], key_y[nxt][i], alpha);
            r.id = 5'(i);
            r.x = clip_int16(((pos_x - 500) * 3) >>> 3);
            r.y = clip_int16(((pos_y - 1000) * 3) >>> 1);
            r.last = (i == npts - 1);
            expected_vertices.push_back(r);
         end
      endfunction

      // Called once for every item the block accepts.
      function void note_item(req_code_type rt, logic [3:0] key, logic [4:0] pt,
                              logic [15:0] x, logic [15:0] y, logic [15:0] len);
         case (rt)
            REQ_VERTEX: begin
               key_x[key][pt] = x;
               key_y[key][pt] = y;
               vertex_loaded[key][pt] = 1'b1;
            end
            REQ_LENGTH: begin
               key_length[key] = len;
               length_loaded[key] = 1'b1;
            end
            REQ_TICK: begin
               predict_tick();
            end
            default: begin
            end
         endcase
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t ns: %s", $time, msg);
         mismatch_count++;
      endtask

      task check_result(logic [4:0] id, logic [15:0] x, logic [15:0] y, logic last);
         vertex_result_type want;
         if (expected_vertices.size() == 0) begin
            report($sformatf("vertex %0d emitted with no result expected", id));
            return;
         end
         want = expected_vertices.pop_front();
         if (id !== want.id)
            report($sformatf("vertex_id %0d, expected %0d", id, want.id));
         if (x !== want.x)
            report($sformatf("vertex %0d out_x %0d, expected %0d", want.id,
                             $signed(x), $signed(want.x)));
         if (y !== want.y)
            report($sformatf("vertex %0d out_y %0d, expected %0d", want.id,
                             $signed(y), $signed(want.y)));
         if (last !== want.last)
            report($sformatf("vertex %0d last_vertex %b, expected %b", want.id,
                             last, want.last));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   req_code_type              req_type;
   logic [3:0]                req_key_index;
   logic [4:0]                req_point_index;
   logic signed [15:0]        req_coord_x;
   logic signed [15:0]        req_coord_y;
   logic [15:0]               req_length_ticks;
   logic                      rsp_valid;
   logic [4:0]                rsp_vertex_id;
   logic signed [15:0]        rsp_out_x;
   logic signed [15:0]        rsp_out_y;
   logic                      rsp_last_vertex;
   logic                      csr_we;
   csr_index_type             csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   interp_scoreboard sb;
   bit               no_gaps;

   keyframe_vertex_interpolator #(
      .MAX_KEYS   (MAX_KEYS),
      .MAX_POINTS (MAX_POINTS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_key_index    (req_key_index),
      .req_point_index  (req_point_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_length_ticks (req_length_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_vertex_id    (rsp_vertex_id),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_last_vertex  (rsp_last_vertex),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Results cannot be held off, so every strobe is checked at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result(rsp_vertex_id, rsp_out_x, rsp_out_y, rsp_last_vertex);
      end
   end

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] rand_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 16'h8000;
      if (pick == 1) return 16'h7FFF;
      if (pick < 5) return 16'($urandom_range(0, 4000) - 2000);
      return 16'($urandom);
   endfunction

   // Short lengths keep the keyframes turning over; zero and full scale show up too.
   function automatic logic [15:0] pick_length();
      int pick;
      pick = $urandom_range(0, 23);
      if (pick == 0) return 16'd0;
      if (pick == 1) return 16'hFFFF;
      if (pick == 2) return 16'($urandom);
      return 16'($urandom_range(1, 6));
   endfunction

   // Presents one item, waits until the block takes it, then idles for a random gap.
   // Called at a rising edge; start is left high when the next item follows at once.
   task automatic send_item(req_code_type rt, logic [3:0] key, logic [4:0] pt,
                            logic [15:0] x, logic [15:0] y, logic [15:0] len);
      int gap;
      req_type <= rt;
      req_key_index <= key;
      req_point_index <= pt;
      req_coord_x <= x;
      req_coord_y <= y;
      req_length_ticks <= len;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_item(rt, key, pt, x, y, len);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // A tick reads the lengths and vertices of the keys in play, so any of them not yet
   // loaded are written first with random content.
   task automatic send_tick();
      int frames;
      int npts;
      frames = sb.frames_in_use();
      npts = sb.points_in_use();
      for (int k = 0; k < MAX_KEYS; k++) begin
         if (k < frames || k == sb.key_now) begin
            if (!sb.length_loaded[k])
               send_item(REQ_LENGTH, 4'(k), 5'($urandom), 16'($urandom), 16'($urandom),
                         pick_length());
            for (int p = 0; p < npts; p++) begin
               if (!sb.vertex_loaded[k][p])
                  send_item(REQ_VERTEX, 4'(k), 5'(p), rand_coord(), rand_coord(),
                            16'($urandom));
            end
         end
      end
      send_item(REQ_TICK, 4'($urandom), 5'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
   endtask

   task automatic write_csr(csr_index_type idx, logic [5:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Waits for every queued vertex, then lets the block finish any trailing work.
   task automatic drain();
      int waited;
      start <= 1'b0;
      waited = 0;
      while ((sb.expected_vertices.size() != 0 || busy) && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      int counted;
      int pick;
      logic [5:0] frames_set;
      logic [5:0] points_set;

      sb = new();
      no_gaps = 1'b0;
      start = 1'b0;
      req_type = REQ_VERTEX;
      req_key_index = '0;
      req_point_index = '0;
      req_coord_x = '0;
      req_coord_y = '0;
      req_length_ticks = '0;
      csr_we = 1'b0;
      csr_index = CSR_FRAME_COUNT;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: four keyframes of two vertices, with a zero and a full-scale length.
      write_csr(CSR_FRAME_COUNT, 6'd4);
      write_csr(CSR_VERTEX_COUNT, 6'd2);
      send_item(REQ_LENGTH, 4'd0, 5'd0, 16'd0, 16'd0, 16'd0);
      send_item(REQ_LENGTH, 4'd1, 5'd0, 16'd0, 16'd0, 16'hFFFF);
      send_item(REQ_LENGTH, 4'd2, 5'd0, 16'd0, 16'd0, 16'd1);
      send_item(REQ_LENGTH, 4'd3, 5'd0, 16'd0, 16'd0, 16'd3);

      // Coordinate extremes, so the transformed y saturates both ways.
      send_item(REQ_VERTEX, 4'd0, 5'd0, 16'h8000, 16'h7FFF, 16'd0);
      send_item(REQ_VERTEX, 4'd0, 5'd1, 16'h7FFF, 16'h8000, 16'd0);
      send_item(REQ_VERTEX, 4'd1, 5'd0, 16'h7FFF, 16'h7FFF, 16'd0);
      send_item(REQ_VERTEX, 4'd1, 5'd1, 16'h8000, 16'h8000, 16'd0);
      send_item(REQ_VERTEX, 4'd2, 5'd0, 16'd0, 16'd0, 16'd0);
      send_item(REQ_VERTEX, 4'd2, 5'd1, 16'd500, 16'd1000, 16'd0);
      send_item(REQ_VERTEX, 4'd3, 5'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      send_item(REQ_VERTEX, 4'd3, 5'd1, 16'd1, 16'd1, 16'd0);

      // The reserved request code is dropped without a result.
      send_item(REQ_RESERVED, 4'hF, 5'h1F, 16'hFFFF, 16'hFFFF, 16'hFFFF);

      // The zero-length key advances at once; the long key then creeps forward.
      repeat (3) send_tick();
      send_item(REQ_LENGTH, 4'd1, 5'd0, 16'd0, 16'd0, 16'd2);
      repeat (3) send_tick();

      // Frame count lowered under the current key: no wrap until the key steps.
      drain();
      write_csr(CSR_FRAME_COUNT, 6'd2);
      repeat (2) send_tick();

      // Frame count of zero acts as one; a vertex count of zero emits nothing.
      drain();
      write_csr(CSR_FRAME_COUNT, 6'd0);
      write_csr(CSR_VERTEX_COUNT, 6'd0);
      repeat (2) send_tick();

      // Random phases: the first runs every vertex on two keys, the second every key
      // with a few vertices, later ones vary.
      for (int ph = 0; ph < PHASE_TOTAL; ph++) begin
         drain();
         case (ph)
            0: begin
               frames_set = 6'd2;
               points_set = 6'd32;
            end
            1: begin
               frames_set = 6'd31;
               points_set = 6'd2;
            end
            2: begin
               frames_set = 6'd1;
               points_set = 6'd1;
            end
            3: begin
               frames_set = 6'd2;
               points_set = 6'd33;
            end
            default: begin
               frames_set = $urandom_range(0, 1) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(1, 4));
               points_set = 6'($urandom_range(0, 8));
            end
         endcase
         write_csr(CSR_FRAME_COUNT, frames_set);
         write_csr(CSR_VERTEX_COUNT, points_set);
         no_gaps = (ph % 3 == 2);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               send_tick();
               counted++;
            end else if (pick < 82) begin
               send_item(REQ_VERTEX, 4'($urandom), 5'($urandom), rand_coord(), rand_coord(),
                         16'($urandom));
               counted++;
            end else if (pick < 94) begin
               send_item(REQ_LENGTH, 4'($urandom), 5'($urandom), 16'($urandom),
                         16'($urandom), pick_length());
               counted++;
            end else begin
               send_item(REQ_RESERVED, 4'($urandom), 5'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
            end
         end
      end

      drain();
      if (sb.expected_vertices.size() != 0)
         sb.report($sformatf("%0d expected vertices never emitted",
                             sb.expected_vertices.size()));
      if (sb.mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(64'd5_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
